// ===== hdl/lifo_pkg.sv =====
// ----------------------------------------------------------------------------
// lifo_pkg
// Shared sizes, codes and word conversions for the bounded LIFO stack.
// ----------------------------------------------------------------------------
package lifo_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]           addr_t;
  typedef logic [CNT_W-1:0]            cnt_t;

  typedef enum logic [2:0] {
    ACT_PUSH      = 3'd0,
    ACT_POP       = 3'd1,
    ACT_REVERSE   = 3'd2,
    ACT_SWAP      = 3'd3,
    ACT_PARTITION = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNDER       = 2'd1,
    ST_OVER        = 2'd2,
    ST_NOT_APPLIED = 2'd3
  } status_t;

  // Keep the low WORD_BITS bits, or sign-extend when the word is wider.
  function automatic word_t to_word(logic signed [31:0] v);
    return WORD_BITS'(v);
  endfunction

  // Sign-extend from WORD_BITS, then cut to 32 bits.
  function automatic logic signed [31:0] from_word(word_t w);
    return 32'(w);
  endfunction

endpackage

// ===== hdl/lifo_stack_with_reorder_ops.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_reorder_ops
// Bounded LIFO stack of signed words with push, pop, reverse, swap of top and
// bottom, and a stable even-below-odd partition.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_action, in_value
//   out_      output     out_valid / out_stall out_data, out_count, out_status
//
// Push, pop and no-op actions go through S_TOP_RD and S_TOP_LD to the result;
// a new item is taken in the cycle after the result leaves. Reverse runs the
// S_RV_* states once per exchanged pair, swap runs them once; partition reads
// all entries on two passes, then copies them back: all entry moves share one
// read and one write port per memory. Reset (synchronous, rst_n low) empties
// the stack; the entry memory is not cleared. in_stall is high from acceptance
// until the result is taken; out_stall holds the result as long as needed.
// ----------------------------------------------------------------------------
module lifo_stack_with_reorder_ops
  import lifo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_data,
  output logic [CNT_W-1:0]   out_count,
  output logic [1:0]         out_status
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_RV_RDA  = 11'b000_0000_0010,
    S_RV_RDB  = 11'b000_0000_0100,
    S_RV_WRA  = 11'b000_0000_1000,
    S_RV_WRB  = 11'b000_0001_0000,
    S_PT_RD   = 11'b000_0010_0000,
    S_PT_WR   = 11'b000_0100_0000,
    S_CP_RD   = 11'b000_1000_0000,
    S_CP_WR   = 11'b001_0000_0000,
    S_TOP_RD  = 11'b010_0000_0000,
    S_TOP_LD  = 11'b100_0000_0000
  } state_t;

  // S_OUT is folded into S_IDLE-blocking via out_valid_r.
  state_t  state_r, state_nxt;
  cnt_t    fill_r, fill_nxt;
  addr_t   lo_r, lo_nxt;
  addr_t   hi_r, hi_nxt;
  addr_t   i_r, i_nxt;
  addr_t   k_r, k_nxt;
  logic    pass_r, pass_nxt;
  logic    swap_r, swap_nxt;
  logic    pop_r, pop_nxt;
  status_t status_r, status_nxt;
  word_t   a_r, a_nxt;
  logic signed [31:0] data_r, data_nxt;
  logic    out_valid_r, out_valid_nxt;

  word_t   mem [DEPTH];
  word_t   scr [DEPTH];
  word_t   mem_rdata_r;
  word_t   scr_rdata_r;
  addr_t   mem_raddr, mem_waddr;
  word_t   mem_wdata;
  logic    mem_we;
  addr_t   scr_waddr;
  logic    scr_we;

  cnt_t    fill_m1;
  addr_t   last_idx;
  addr_t   span;
  logic    in_acc;

  assign fill_m1  = fill_r - 1'b1;
  assign last_idx = fill_m1[ADDR_W-1:0];
  assign span     = hi_r - lo_r;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid  = out_valid_r;
  assign out_data   = data_r;
  assign out_count  = fill_r;
  assign out_status = status_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr[scr_waddr] <= mem_rdata_r;
    end
    scr_rdata_r <= scr[i_r];
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    pass_nxt      = pass_r;
    swap_nxt      = swap_r;
    pop_nxt       = pop_r;
    status_nxt    = status_r;
    a_nxt         = a_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r;
    mem_raddr     = '0;
    mem_waddr     = '0;
    mem_wdata     = mem_rdata_r;
    mem_we        = 1'b0;
    scr_waddr     = k_r;
    scr_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (out_valid_r && !out_stall) begin
          out_valid_nxt = 1'b0;
        end
        if (in_acc) begin
          status_nxt = ST_OK;
          pop_nxt    = 1'b0;
          state_nxt  = S_TOP_RD;
          case (act_t'(in_action))
            ACT_PUSH: begin
              if (fill_r == CNT_W'(DEPTH)) begin
                status_nxt = ST_OVER;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = fill_r[ADDR_W-1:0];
                mem_wdata = to_word(in_value);
                fill_nxt  = fill_r + 1'b1;
              end
            end
            ACT_POP: begin
              if (fill_r == '0) begin
                status_nxt = ST_UNDER;
              end else begin
                fill_nxt = fill_m1;
                pop_nxt  = 1'b1;
              end
            end
            ACT_REVERSE: begin
              lo_nxt   = '0;
              hi_nxt   = last_idx;
              swap_nxt = 1'b0;
              if (fill_r == '0) begin
                status_nxt = ST_NOT_APPLIED;
              end else if (fill_r != CNT_W'(1)) begin
                state_nxt = S_RV_RDA;
              end
            end
            ACT_SWAP: begin
              lo_nxt   = '0;
              hi_nxt   = last_idx;
              swap_nxt = 1'b1;
              if (fill_r < CNT_W'(2)) begin
                status_nxt = ST_NOT_APPLIED;
              end else begin
                state_nxt = S_RV_RDA;
              end
            end
            ACT_PARTITION: begin
              i_nxt    = '0;
              k_nxt    = '0;
              pass_nxt = 1'b0;
              if (fill_r != '0) begin
                state_nxt = S_PT_RD;
              end
            end
            default: begin
              status_nxt = ST_NOT_APPLIED;
            end
          endcase
        end
      end

      S_RV_RDA: begin
        mem_raddr = lo_r;
        state_nxt = S_RV_RDB;
      end

      S_RV_RDB: begin
        mem_raddr = hi_r;
        a_nxt     = mem_rdata_r;
        state_nxt = S_RV_WRA;
      end

      S_RV_WRA: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = mem_rdata_r;
        state_nxt = S_RV_WRB;
      end

      S_RV_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = a_r;
        lo_nxt    = lo_r + 1'b1;
        hi_nxt    = hi_r - 1'b1;
        // advance while the next pair still has two distinct entries
        if (!swap_r && ({1'b0, span} > (ADDR_W + 1)'(2))) begin
          state_nxt = S_RV_RDA;
        end else begin
          state_nxt = S_TOP_RD;
        end
      end

      S_PT_RD: begin
        mem_raddr = i_r;
        state_nxt = S_PT_WR;
      end

      S_PT_WR: begin
        // even values on the first pass, odd values on the second
        if (mem_rdata_r[0] == pass_r) begin
          scr_we = 1'b1;
          k_nxt  = k_r + 1'b1;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_PT_RD;
        if (i_r == last_idx) begin
          i_nxt = '0;
          if (!pass_r) begin
            pass_nxt = 1'b1;
          end else begin
            state_nxt = S_CP_RD;
          end
        end
      end

      S_CP_RD: begin
        state_nxt = S_CP_WR;
      end

      S_CP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = scr_rdata_r;
        i_nxt     = i_r + 1'b1;
        if (i_r == last_idx) begin
          state_nxt = S_TOP_RD;
        end else begin
          state_nxt = S_CP_RD;
        end
      end

      S_TOP_RD: begin
        // a pop reads the entry just dropped, anything else the new top
        mem_raddr = pop_r ? fill_r[ADDR_W-1:0] : last_idx;
        state_nxt = S_TOP_LD;
      end

      S_TOP_LD: begin
        if (pop_r || (fill_r != '0)) begin
          data_nxt = from_word(mem_rdata_r);
        end else begin
          data_nxt = '0;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      pop_r       <= 1'b0;
      swap_r      <= 1'b0;
      pass_r      <= 1'b0;
      status_r    <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      pop_r       <= pop_nxt;
      swap_r      <= swap_nxt;
      pass_r      <= pass_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    a_r    <= a_nxt;
    data_r <= data_nxt;
  end

endmodule
